/* hw/rtl/hkm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotkey matcher package
// Shared defaults and item opcodes for the hotkey combination matcher.
// ----------------------------------------------------------------------------
package hkm_pkg;

    localparam int NUM_KEYS_DEF    = 256;
    localparam int NUM_HOTKEYS_DEF = 8;

    localparam int OPCODE_W   = 2;
    localparam int KEY_CODE_W = 8;
    localparam int SLOT_W     = 3;
    localparam int MASK_W     = 8;

    localparam logic [OPCODE_W-1:0] OP_KEY_EVENT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD_KEY   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PRESET    = 2'd2;

endpackage

/* hw/rtl/hkm_key_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotkey matcher key store
// One entry per key: pressed flag above the slot membership mask.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hkm_key_store #(
    parameter int NUM_KEYS    = hkm_pkg::NUM_KEYS_DEF,
    parameter int NUM_HOTKEYS = hkm_pkg::NUM_HOTKEYS_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(NUM_KEYS)-1:0] wr_addr,
    input  logic [NUM_HOTKEYS:0]        wr_data,
    input  logic [$clog2(NUM_KEYS)-1:0] rd_addr,
    output logic [NUM_HOTKEYS:0]        rd_data
);

    logic [NUM_HOTKEYS:0] mem [NUM_KEYS];
    logic [NUM_HOTKEYS:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/hotkey_combination_matcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotkey combination matcher
// Pressed map and slot membership per key, per-slot block and active flags,
// and one result per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until its single result has been shown. The result appears for exactly one
// cycle with done high and cannot be held off, so the receiver must take it
// then. An unknown opcode or an out-of-range key (or slot, for add-key) goes
// straight to the done state; add-key, preset and key events on keys in no
// hotkey pass through fetch and modify; a key event on a hotkey key also
// walks over every key-store entry through the single read port, then
// drains before done. After reset busy is high while the key store is
// cleared one entry a cycle.
// ----------------------------------------------------------------------------
module hotkey_combination_matcher_top #(
    parameter int NUM_KEYS    = hkm_pkg::NUM_KEYS_DEF,
    parameter int NUM_HOTKEYS = hkm_pkg::NUM_HOTKEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hkm_pkg::OPCODE_W-1:0]    opcode,
    input  logic [hkm_pkg::KEY_CODE_W-1:0]  key_code,
    input  logic                            key_down,
    input  logic [hkm_pkg::SLOT_W-1:0]      hotkey_slot,
    input  logic                            block_flag,
    output logic                            done,
    output logic                            suppress,
    output logic [hkm_pkg::MASK_W-1:0]      active_mask,
    output logic [hkm_pkg::MASK_W-1:0]      previous_active_mask
);

    localparam int KEY_AW = $clog2(NUM_KEYS);
    localparam int KW     = (KEY_AW + 1 > hkm_pkg::KEY_CODE_W) ? KEY_AW + 1
                                                               : hkm_pkg::KEY_CODE_W;
    localparam int SW     = 8;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(NUM_KEYS - 1);

    logic [2:0]                     state_reg, state_next;
    logic [KEY_AW-1:0]              cnt_reg, cnt_next;
    logic                           scan_vld_reg, scan_vld_next;
    logic [NUM_HOTKEYS-1:0]         registered_reg, registered_next;
    logic [NUM_HOTKEYS-1:0]         blocks_reg, blocks_next;
    logic [NUM_HOTKEYS-1:0]         active_reg, active_next;
    logic [NUM_HOTKEYS-1:0]         prev_reg, prev_next;
    logic                           suppress_reg, suppress_next;

    logic [hkm_pkg::OPCODE_W-1:0]   opcode_reg;
    logic [KEY_AW-1:0]              key_reg;
    logic                           key_down_reg;
    logic [NUM_HOTKEYS-1:0]         slot_bit_reg;
    logic                           block_reg;
    logic [NUM_HOTKEYS-1:0]         kmask_reg, kmask_next;
    logic [NUM_HOTKEYS-1:0]         all_down_reg, all_down_next;

    logic [KW-1:0]                  key_wide;
    logic                           key_ok;
    logic                           slot_ok;
    logic                           cmd_ok;
    logic                           accept;

    logic                           wr_en;
    logic [KEY_AW-1:0]              wr_addr;
    logic [NUM_HOTKEYS:0]           wr_data;
    logic [KEY_AW-1:0]              rd_addr;
    logic [NUM_HOTKEYS:0]           rd_data;
    logic                           rd_pressed;
    logic [NUM_HOTKEYS-1:0]         rd_member;
    logic [NUM_HOTKEYS-1:0]         all_down_fold;

    assign key_wide   = KW'(key_code);
    assign key_ok     = key_wide < KW'(NUM_KEYS);
    assign slot_ok    = SW'(hotkey_slot) < SW'(NUM_HOTKEYS);
    assign accept     = start && (state_reg == ST_IDLE);
    assign rd_pressed = rd_data[NUM_HOTKEYS];
    assign rd_member  = rd_data[NUM_HOTKEYS-1:0];

    always_comb
    begin
        case (opcode)
            hkm_pkg::OP_KEY_EVENT: cmd_ok = key_ok;
            hkm_pkg::OP_PRESET:    cmd_ok = key_ok;
            hkm_pkg::OP_ADD_KEY:   cmd_ok = key_ok && slot_ok;
            default:               cmd_ok = 1'b0;
        endcase
    end

    // fold one returned entry into the all-down accumulator
    always_comb
    begin
        all_down_fold = all_down_reg;
        if (scan_vld_reg && !rd_pressed)
        begin
            all_down_fold = all_down_reg & ~rd_member;
        end
    end

    hkm_key_store #(
        .NUM_KEYS    (NUM_KEYS),
        .NUM_HOTKEYS (NUM_HOTKEYS)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_vld_next   = 1'b0;
        registered_next = registered_reg;
        blocks_next     = blocks_reg;
        active_next     = active_reg;
        prev_next       = prev_reg;
        suppress_next   = suppress_reg;
        kmask_next      = kmask_reg;
        all_down_next   = all_down_fold;
        wr_en           = 1'b0;
        wr_addr         = key_reg;
        wr_data         = '0;
        rd_addr         = key_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_KEY)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    suppress_next = 1'b0;
                    state_next    = cmd_ok ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                wr_en      = 1'b1;
                state_next = ST_DONE;
                if (opcode_reg == hkm_pkg::OP_ADD_KEY)
                begin
                    wr_data         = {rd_pressed, rd_member | slot_bit_reg};
                    registered_next = registered_reg | slot_bit_reg;
                    blocks_next     = block_reg ? (blocks_reg | slot_bit_reg)
                                                : (blocks_reg & ~slot_bit_reg);
                end
                else
                begin
                    wr_data = {key_down_reg, rd_member};
                    if ((opcode_reg == hkm_pkg::OP_KEY_EVENT) && (rd_member != '0))
                    begin
                        kmask_next    = rd_member;
                        all_down_next = '1;
                        cnt_next      = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr       = cnt_reg;
                scan_vld_next = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_KEY)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                prev_next     = (prev_reg & ~registered_reg) | (active_reg & registered_reg);
                active_next   = (active_reg & ~registered_reg) | (all_down_fold & registered_reg);
                suppress_next = |(active_next & registered_reg & blocks_reg & kmask_reg);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            scan_vld_reg   <= 1'b0;
            registered_reg <= '0;
            blocks_reg     <= '0;
            active_reg     <= '0;
            prev_reg       <= '0;
            suppress_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            scan_vld_reg   <= scan_vld_next;
            registered_reg <= registered_next;
            blocks_reg     <= blocks_next;
            active_reg     <= active_next;
            prev_reg       <= prev_next;
            suppress_reg   <= suppress_next;
        end
    end

    // hold the command fields for the whole transfer; also register the key mask and all-down accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg   <= opcode;
            key_reg      <= key_wide[KEY_AW-1:0];
            key_down_reg <= key_down;
            slot_bit_reg <= NUM_HOTKEYS'(1) << hotkey_slot;
            block_reg    <= block_flag;
        end
        kmask_reg    <= kmask_next;
        all_down_reg <= all_down_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign suppress = suppress_reg;

    genvar g;
    generate
        for (g = 0; g < hkm_pkg::MASK_W; g++)
        begin : g_mask
            if (g < NUM_HOTKEYS)
            begin : g_slot
                assign active_mask[g]          = active_reg[g];
                assign previous_active_mask[g] = prev_reg[g];
            end
            else
            begin : g_none
                assign active_mask[g]          = 1'b0;
                assign previous_active_mask[g] = 1'b0;
            end
        end
    endgenerate

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer");

    a_suppress_done: assert property (@(posedge clk) disable iff (!rst_n)
        suppress_reg |-> (state_reg == ST_DONE || state_reg == ST_IDLE))
        else $error("suppress set outside result delivery");

    a_active_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DRAIN) |=> $stable(active_reg))
        else $error("active flags changed outside evaluation");
`endif

endmodule
